// ----- design/wsp_pkg.sv -----
// Shared constants, codes and table types for the weighted stop-to-position block.
package wsp_pkg;

    // Sizing
    localparam int NUM_REELS   = 8;
    localparam int MAX_STOPS   = 256;
    localparam int WEIGHT_BITS = 16;

    // Field widths
    localparam int REEL_W     = 3;
    localparam int INDEX_W    = 8;
    localparam int WEIGHT_W   = 16;
    localparam int STOP_W     = 24;
    localparam int POS_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int ZERO_W     = 8;

    // Stream widths: fields packed from bit 0, padded to whole bytes
    localparam int S_FIELDS_W = REEL_W + INDEX_W + WEIGHT_W + STOP_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = REEL_W + POS_W + STATUS_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Derived table geometry
    localparam int REEL_IDX_W = (NUM_REELS > 1) ? $clog2(NUM_REELS) : 1;
    localparam int IDX_W      = $clog2(MAX_STOPS);
    localparam int CNT_W      = $clog2(MAX_STOPS + 1);
    localparam int TAB_AW     = REEL_IDX_W + IDX_W;
    localparam int TAB_DEPTH  = 1 << TAB_AW;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MASK =
        WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);
    localparam logic [STOP_W-1:0]   TOTAL_MAX   = '1;
    localparam logic [ZERO_W-1:0]   ZERO_MAX    = '1;

    // Request kinds (tuser)
    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_CONVERT = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // One table entry: cumulative weight and zero-weight positions before it
    typedef struct packed {
        logic [STOP_W-1:0] cum;
        logic [ZERO_W-1:0] zeros;
    } t_tab_entry;

    // Sequencer to table: one write port, one read port
    typedef struct packed {
        logic              we;
        logic [TAB_AW-1:0] waddr;
        t_tab_entry        wdata;
        logic              re;
        logic [TAB_AW-1:0] raddr;
    } t_tab_req;

endpackage

// ----- design/wsp_table.sv -----
// Cumulative weight table for all reels: one write and one registered read per cycle.
module wsp_table (
    input  logic                i_clk,
    input  wsp_pkg::t_tab_req   i_req,
    output wsp_pkg::t_tab_entry o_rd_data
);
    import wsp_pkg::*;

    t_tab_entry mem [TAB_DEPTH];
    t_tab_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/weighted_stop_to_position_top.sv -----
// Top level: microcoded sequencer, per-reel counters and output register.
//
//  channel | direction | tdata (low bit up)                         | tuser
//  --------+-----------+--------------------------------------------+-----------------
//  s       | in        | reel, entry_index, weight, stop, zero pad  | func
//  m       | out       | out_reel, position, status, zero pad       | -
//
// A weight write runs accept and table update; a convert with an error status runs
// accept, check and emit. Any other convert runs accept, check, binary search probes
// (at most 9 for 256 entries), clamp, emit; a probe is one table read then a compare.
// One request is worked on at a time; the next is accepted while a result waits.
// Reset (synchronous, active low) clears counters and totals; the table is not cleared.
// A stalled result holds the sequencer in its emit step only when the output is full.
module weighted_stop_to_position_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // reel[2:0], entry_index[10:3], weight[26:11], stop[50:27], pad
    input  logic [wsp_pkg::S_TDATA_W-1:0] i_s_tdata,
    // func[0]
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // out_reel[2:0], position[10:3], status[12:11], pad
    output logic [wsp_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import wsp_pkg::*;

    // Microcode
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [2:0] {
        OP_NOP, OP_ACCEPT, OP_WRITE, OP_CHECK, OP_PROBE, OP_NARROW, OP_CLAMP, OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        CND_NEXT, CND_JMP, CND_IN, CND_FAIL, CND_DONE, CND_OUT
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    localparam t_step STEP_IDLE  = 3'd0;
    localparam t_step STEP_WRITE = 3'd1;
    localparam t_step STEP_CHECK = 3'd2;
    localparam t_step STEP_PROBE = 3'd3;
    localparam t_step STEP_CMP   = 3'd4;
    localparam t_step STEP_CLAMP = 3'd5;
    localparam t_step STEP_EMIT  = 3'd6;

    function automatic t_uword ucode_rom(input t_step step);
        t_uword uw;
        unique case (step)
            STEP_IDLE:  uw = '{op: OP_ACCEPT, cond: CND_IN,   target: STEP_CHECK};
            STEP_WRITE: uw = '{op: OP_WRITE,  cond: CND_JMP,  target: STEP_IDLE};
            STEP_CHECK: uw = '{op: OP_CHECK,  cond: CND_FAIL, target: STEP_EMIT};
            STEP_PROBE: uw = '{op: OP_PROBE,  cond: CND_DONE, target: STEP_CLAMP};
            STEP_CMP:   uw = '{op: OP_NARROW, cond: CND_JMP,  target: STEP_PROBE};
            STEP_CLAMP: uw = '{op: OP_CLAMP,  cond: CND_NEXT, target: STEP_IDLE};
            STEP_EMIT:  uw = '{op: OP_EMIT,   cond: CND_OUT,  target: STEP_IDLE};
            default:    uw = '{op: OP_NOP,    cond: CND_JMP,  target: STEP_IDLE};
        endcase
        return uw;
    endfunction

    // Registers
    t_step                 r_step;
    logic                  r_func;
    logic [REEL_W-1:0]     r_reel;
    logic [INDEX_W-1:0]    r_idx;
    logic [WEIGHT_W-1:0]   r_wt;
    logic [STOP_W-1:0]     r_stop;
    logic [CNT_W-1:0]      r_lo;
    logic [CNT_W-1:0]      r_hi;
    logic [CNT_W-1:0]      r_mid;
    logic [STATUS_W-1:0]   r_status;
    logic [CNT_W-1:0]      r_nz  [NUM_REELS];
    logic [ZERO_W-1:0]     r_zc  [NUM_REELS];
    logic [STOP_W-1:0]     r_tot [NUM_REELS];
    logic                  r_out_valid;
    logic [M_TDATA_W-1:0]  r_out_data;

    t_step                 n_step;
    logic [CNT_W-1:0]      n_nz;
    logic [ZERO_W-1:0]     n_zc;
    logic [STOP_W-1:0]     n_tot;

    t_uword                uw;
    t_tab_req              tab_req;
    t_tab_entry            tab_rd;

    logic                  in_acc;
    logic                  out_free;
    logic [REEL_IDX_W-1:0] sel;
    logic                  reel_ok;
    logic [CNT_W-1:0]      cur_nz;
    logic [STOP_W-1:0]     cur_tot;
    logic                  restart;
    logic [CNT_W-1:0]      base_nz;
    logic [ZERO_W-1:0]     base_zc;
    logic [STOP_W-1:0]     base_tot;
    logic [WEIGHT_W-1:0]   w;
    logic [STOP_W:0]       sum;
    logic [STOP_W-1:0]     sat_tot;
    logic                  can_add;
    logic [CNT_W:0]        mid_sum;
    logic [CNT_W-1:0]      mid;
    logic [CNT_W-1:0]      lo_fix;
    logic                  chk_empty;
    logic                  chk_range;
    logic [POS_W-1:0]      pos;

    assign uw       = ucode_rom(r_step);
    assign in_acc   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    // Per-reel state of the request held
    assign sel      = REEL_IDX_W'(r_reel);
    assign reel_ok  = (32'(r_reel) < NUM_REELS);
    assign cur_nz   = r_nz[sel];
    assign cur_tot  = r_tot[sel];
    assign restart  = (r_idx == '0);
    assign base_nz  = restart ? '0 : cur_nz;
    assign base_zc  = restart ? '0 : r_zc[sel];
    assign base_tot = restart ? '0 : cur_tot;

    // Weight accumulation with saturation
    assign w        = r_wt & WEIGHT_MASK;
    assign sum      = {1'b0, base_tot} + (STOP_W+1)'(w);
    assign sat_tot  = sum[STOP_W] ? TOTAL_MAX : sum[STOP_W-1:0];
    assign can_add  = (base_nz < CNT_W'(MAX_STOPS));

    always_comb begin
        n_nz  = base_nz;
        n_zc  = base_zc;
        n_tot = base_tot;
        if (w == '0) begin
            if (base_zc != ZERO_MAX) n_zc = base_zc + 1'b1;
        end else if (can_add) begin
            n_nz  = base_nz + 1'b1;
            n_tot = sat_tot;
        end
    end

    // Search datapath
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = mid_sum[CNT_W:1];
    assign lo_fix    = (r_lo >= cur_nz) ? cur_nz - 1'b1 : r_lo;
    assign chk_empty = !reel_ok || (cur_nz == '0);
    assign chk_range = (r_stop >= cur_tot);
    assign pos       = POS_W'(r_lo) + tab_rd.zeros;

    // Table port
    always_comb begin
        tab_req       = '0;
        tab_req.we    = (uw.op == OP_WRITE) && reel_ok && (w != '0) && can_add;
        tab_req.waddr = {sel, IDX_W'(base_nz)};
        tab_req.wdata = '{cum: sat_tot, zeros: base_zc};
        tab_req.re    = (uw.op == OP_PROBE) || (uw.op == OP_CLAMP);
        tab_req.raddr = (uw.op == OP_CLAMP) ? {sel, IDX_W'(lo_fix)} : {sel, IDX_W'(mid)};
    end

    wsp_table u_table (
        .i_clk     (i_clk),
        .i_req     (tab_req),
        .o_rd_data (tab_rd)
    );

    // Step sequencing
    always_comb begin
        unique case (uw.cond)
            CND_NEXT: n_step = r_step + 1'b1;
            CND_JMP:  n_step = uw.target;
            CND_IN: begin
                if (!in_acc)                        n_step = r_step;
                else if (i_s_tuser == FUNC_CONVERT) n_step = uw.target;
                else                                n_step = r_step + 1'b1;
            end
            CND_FAIL: n_step = (chk_empty || chk_range) ? uw.target : r_step + 1'b1;
            CND_DONE: n_step = (r_lo >= r_hi) ? uw.target : r_step + 1'b1;
            CND_OUT:  n_step = out_free ? uw.target : r_step;
            default:  n_step = STEP_IDLE;
        endcase
    end

    // Control state, counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_REELS; i++) begin
                r_nz[i]  <= '0;
                r_zc[i]  <= '0;
                r_tot[i] <= '0;
            end
        end else begin
            r_step <= n_step;
            if (uw.op == OP_WRITE && reel_ok) begin
                r_nz[sel]  <= n_nz;
                r_zc[sel]  <= n_zc;
                r_tot[sel] <= n_tot;
            end
            if (uw.op == OP_EMIT && out_free) r_out_valid <= 1'b1;
            else if (i_m_tready)              r_out_valid <= 1'b0;
        end
    end

    // Request fields, search bounds and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func <= i_s_tuser;
            r_reel <= i_s_tdata[REEL_W-1:0];
            r_idx  <= i_s_tdata[REEL_W +: INDEX_W];
            r_wt   <= i_s_tdata[REEL_W+INDEX_W +: WEIGHT_W];
            r_stop <= i_s_tdata[REEL_W+INDEX_W+WEIGHT_W +: STOP_W];
        end
        unique case (uw.op)
            OP_CHECK: begin
                r_lo <= '0;
                r_hi <= cur_nz;
                if (chk_empty)      r_status <= STAT_EMPTY;
                else if (chk_range) r_status <= STAT_RANGE;
                else                r_status <= STAT_OK;
            end
            OP_PROBE:  r_mid <= mid;
            OP_NARROW: begin
                if (r_stop < tab_rd.cum) r_hi <= r_mid;
                else                     r_lo <= r_mid + 1'b1;
            end
            OP_CLAMP:  r_lo <= lo_fix;
            OP_EMIT: begin
                if (out_free && r_func == FUNC_CONVERT) begin
                    r_out_data <= M_TDATA_W'({r_status,
                                              (r_status == STAT_OK) ? pos : POS_W'(0),
                                              r_reel});
                end
            end
            default: ;
        endcase
    end

    // No request is taken while reset is held
    assign o_s_tready = (uw.op == OP_ACCEPT) && i_rst_n;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ----- design/wsp_checker.sv -----
// Port-level checks on the weighted stop-to-position top level, bound to it.
module wsp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [wsp_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import wsp_pkg::*;

    localparam int STAT_LSB = REEL_W + POS_W;

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // Only defined status codes leave the block
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[STAT_LSB +: STATUS_W] == STAT_OK)
                    || (o_m_tdata[STAT_LSB +: STATUS_W] == STAT_RANGE)
                    || (o_m_tdata[STAT_LSB +: STATUS_W] == STAT_EMPTY))
        else $error("undefined status");

    // Error results carry position zero
    a_err_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[STAT_LSB +: STATUS_W] != STAT_OK)
        |-> (o_m_tdata[REEL_W +: POS_W] == '0))
        else $error("error result with nonzero position");

    // The cycle after a request is taken takes no request and raises no result
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready && !$rose(o_m_tvalid))
        else $error("sequencer did not hold after a request");

endmodule

bind weighted_stop_to_position_top wsp_checker u_wsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ----- verif/weighted_stop_to_position_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the weighted stop-to-position block.
module weighted_stop_to_position_top_tb;
    import wsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int IDLE_PCT       = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_CYCLES   = 40;

    // One request on the slave stream
    typedef struct packed {
        logic                func;
        logic [REEL_W-1:0]   reel;
        logic [INDEX_W-1:0]  idx;
        logic [WEIGHT_W-1:0] weight;
        logic [STOP_W-1:0]   stop;
    } t_stop_req;

    // One result on the master stream
    typedef struct packed {
        logic [REEL_W-1:0]   reel;
        logic [POS_W-1:0]    pos;
        logic [STATUS_W-1:0] status;
    } t_stop_res;

    // Directed row: request plus optional hand-written answer
    typedef struct {
        t_stop_req req;
        bit        typed;
        t_stop_res want;
    } t_plan_row;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                 i_s_tuser  = FUNC_WRITE;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;

    // Shadow of the reel tables
    logic [STOP_W-1:0] cum_tab   [NUM_REELS*MAX_STOPS];
    logic [ZERO_W-1:0] zeros_tab [NUM_REELS*MAX_STOPS];
    int unsigned       nz_cnt    [NUM_REELS];
    int unsigned       zero_cnt  [NUM_REELS];
    logic [STOP_W-1:0] reel_sum  [NUM_REELS];

    t_stop_res pending_positions[$];
    t_plan_row plan[$];
    int        mismatch_cnt = 0;
    int        req_cnt      = 0;
    int        res_cnt      = 0;
    int        status_cnt[3];
    int        quiet_cycles = 0;
    bit        no_gap       = 1'b0;

    weighted_stop_to_position_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow update for a weight write
    function automatic void apply_weight_write(logic [REEL_W-1:0] reel, logic [INDEX_W-1:0] idx,
                                               logic [WEIGHT_W-1:0] weight);
        int unsigned       n;
        logic [STOP_W:0]   sum;
        logic [WEIGHT_W-1:0] w;
        if (int'(reel) >= NUM_REELS) return;
        if (idx == '0) begin
            nz_cnt[reel]   = 0;
            zero_cnt[reel] = 0;
            reel_sum[reel] = '0;
        end
        w = weight & WEIGHT_MASK;
        if (w == '0) begin
            if (zero_cnt[reel] < ZERO_MAX) zero_cnt[reel]++;
            return;
        end
        n = nz_cnt[reel];
        if (n >= MAX_STOPS) return;
        sum = {1'b0, reel_sum[reel]} + (STOP_W+1)'(w);
        if (sum > {1'b0, TOTAL_MAX}) sum = {1'b0, TOTAL_MAX};
        reel_sum[reel] = sum[STOP_W-1:0];
        cum_tab[int'(reel)*MAX_STOPS + n]   = sum[STOP_W-1:0];
        zeros_tab[int'(reel)*MAX_STOPS + n] = ZERO_W'(zero_cnt[reel]);
        nz_cnt[reel] = n + 1;
    endfunction

    // Upper-bound search of a stop over the reel's cumulative weights
    function automatic t_stop_res locate_stop(logic [REEL_W-1:0] reel, logic [STOP_W-1:0] stop);
        t_stop_res   res;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned base;
        res.reel   = reel;
        res.pos    = '0;
        res.status = STAT_OK;
        if (int'(reel) >= NUM_REELS || nz_cnt[reel] == 0) begin
            res.status = STAT_EMPTY;
            return res;
        end
        if (stop >= reel_sum[reel]) begin
            res.status = STAT_RANGE;
            return res;
        end
        base = int'(reel) * MAX_STOPS;
        lo   = 0;
        hi   = nz_cnt[reel];
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (stop < cum_tab[base + mid]) hi = mid;
            else lo = mid + 1;
        end
        if (lo >= nz_cnt[reel]) lo = nz_cnt[reel] - 1;
        res.pos = POS_W'(lo + zeros_tab[base + lo]);
        return res;
    endfunction

    function automatic void add_row(logic func, int reel, int idx, int weight, int stop,
                                    bit typed = 1'b0, logic [STATUS_W-1:0] status = STAT_OK);
        t_plan_row row;
        row.req.func    = func;
        row.req.reel    = REEL_W'(reel);
        row.req.idx     = INDEX_W'(idx);
        row.req.weight  = WEIGHT_W'(weight);
        row.req.stop    = STOP_W'(stop);
        row.typed       = typed;
        row.want.reel   = REEL_W'(reel);
        row.want.pos    = '0;
        row.want.status = status;
        plan = {plan, row};
    endfunction

    // Zero, small, any or full-scale weights, any-range weights the most common
    function automatic logic [WEIGHT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return '0;
        if (r < 45) return WEIGHT_W'($urandom_range(1, 15));
        if (r < 85) return WEIGHT_W'($urandom_range(1, 65535));
        return '1;
    endfunction

    // Mostly in range, with the edges around the reel total
    function automatic logic [STOP_W-1:0] pick_stop(logic [REEL_W-1:0] reel);
        int r;
        r = $urandom_range(0, 99);
        if (nz_cnt[reel] == 0 || r >= 92) return STOP_W'($urandom);
        if (r < 75) return STOP_W'($urandom_range(0, 32'(reel_sum[reel]) - 1));
        if (r < 82) return reel_sum[reel] - 1'b1;
        if (r < 88) return reel_sum[reel];
        return '0;
    endfunction

    // Present one request with random gaps ahead of it; called at a falling edge
    task automatic send_request(input t_stop_req req, input bit typed, input t_stop_res want);
        t_stop_res exp_res;
        while (!no_gap && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req.func;
        i_s_tdata  <= S_TDATA_W'({req.stop, req.weight, req.idx, req.reel});
        do @(posedge i_clk); while (!o_s_tready);
        req_cnt++;
        if (req.func == FUNC_WRITE) apply_weight_write(req.reel, req.idx, req.weight);
        else begin
            exp_res           = typed ? want : locate_stop(req.reel, req.stop);
            pending_positions = {pending_positions, exp_res};
        end
        @(negedge i_clk);
    endtask

    // Unused fields carry random junk so their bits toggle too
    task automatic send_write(input int reel, input int idx, input logic [WEIGHT_W-1:0] weight);
        t_stop_req req;
        req.func   = FUNC_WRITE;
        req.reel   = REEL_W'(reel);
        req.idx    = INDEX_W'(idx);
        req.weight = weight;
        req.stop   = STOP_W'($urandom);
        send_request(req, 1'b0, '0);
    endtask

    task automatic send_convert(input int reel);
        t_stop_req req;
        req.func   = FUNC_CONVERT;
        req.reel   = REEL_W'(reel);
        req.idx    = INDEX_W'($urandom);
        req.weight = WEIGHT_W'($urandom);
        req.stop   = pick_stop(REEL_W'(reel));
        send_request(req, 1'b0, '0);
    endtask

    // Stimulus
    initial begin
        int start_cnt;
        int seq_no;
        int kind;
        int reel;
        int n;

        for (int r = 0; r < NUM_REELS; r++) begin
            nz_cnt[r]   = 0;
            zero_cnt[r] = 0;
            reel_sum[r] = '0;
        end
        for (int s = 0; s < 3; s++) status_cnt[s] = 0;

        //       func          reel idx  weight    stop      typed status
        add_row(FUNC_CONVERT, 0,   0,   0,        0,        1'b1, STAT_EMPTY);
        add_row(FUNC_CONVERT, 7,   255, 65535,    16777215, 1'b1, STAT_EMPTY);
        add_row(FUNC_WRITE,   0,   0,   0,        0);
        add_row(FUNC_WRITE,   0,   1,   1,        0);
        add_row(FUNC_WRITE,   0,   2,   65535,    0);
        add_row(FUNC_WRITE,   0,   255, 0,        16777215);
        add_row(FUNC_WRITE,   0,   3,   10,       0);
        add_row(FUNC_CONVERT, 0,   0,   0,        0);
        add_row(FUNC_CONVERT, 0,   0,   0,        1);
        add_row(FUNC_CONVERT, 0,   0,   0,        65545);
        add_row(FUNC_CONVERT, 0,   0,   0,        65546,    1'b1, STAT_RANGE);
        add_row(FUNC_CONVERT, 0,   0,   0,        16777215, 1'b1, STAT_RANGE);
        add_row(FUNC_WRITE,   1,   0,   0,        0);
        add_row(FUNC_CONVERT, 1,   0,   0,        0,        1'b1, STAT_EMPTY);
        add_row(FUNC_WRITE,   5,   0,   65535,    0);
        add_row(FUNC_WRITE,   5,   7,   1,        0);
        add_row(FUNC_CONVERT, 5,   0,   0,        65534);
        add_row(FUNC_CONVERT, 5,   0,   0,        65535);
        add_row(FUNC_WRITE,   5,   0,   0,        0);
        add_row(FUNC_CONVERT, 5,   0,   0,        0,        1'b1, STAT_EMPTY);
        add_row(FUNC_WRITE,   6,   0,   3,        0);
        add_row(FUNC_CONVERT, 6,   0,   0,        2);
        add_row(FUNC_CONVERT, 6,   0,   0,        3,        1'b1, STAT_RANGE);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table
        foreach (plan[i]) send_request(plan[i].req, plan[i].typed, plan[i].want);

        // Random reel programmes followed by conversions
        start_cnt = req_cnt;
        seq_no    = 0;
        while (req_cnt < start_cnt + RANDOM_ITEMS) begin
            // the two opening floods run to about 575 requests; the gapless stretch follows
            no_gap = (req_cnt >= start_cnt + 600) && (req_cnt < start_cnt + 850);
            reel   = $urandom_range(0, NUM_REELS - 1);
            if (seq_no == 0) kind = 0;
            else if (seq_no == 1) kind = 1;
            else begin
                kind = $urandom_range(0, 99);
                kind = (kind < 3) ? 0 : (kind < 6) ? 1 : (kind < 85) ? 2 : 3;
            end
            seq_no++;
            case (kind)
                0: begin
                    // zero flood: the zero count saturates and positions wrap
                    send_write(reel, 0, '0);
                    for (int k = 1; k < 280; k++) send_write(reel, 1 + (k % 255), '0);
                    for (int k = 0; k < 6; k++)
                        send_write(reel, 1 + k, WEIGHT_W'($urandom_range(1, 65535)));
                    repeat (8) send_convert(reel);
                end
                1: begin
                    // overfill: entries past the table size are dropped
                    send_write(reel, 0, WEIGHT_W'($urandom_range(1, 65535)));
                    for (int k = 1; k < 270; k++)
                        send_write(reel, 1 + (k % 255), WEIGHT_W'($urandom_range(1, 65535)));
                    repeat (10) send_convert(reel);
                end
                2: begin
                    n = $urandom_range(1, 24);
                    send_write(reel, 0, pick_weight());
                    for (int k = 1; k < n; k++) send_write(reel, k, pick_weight());
                    repeat ($urandom_range(2, 10)) begin
                        if ($urandom_range(0, 99) < 60) send_convert(reel);
                        else send_convert($urandom_range(0, NUM_REELS - 1));
                    end
                end
                default: begin
                    // noise: any field, any order
                    repeat (10) begin
                        t_stop_req req;
                        req.func   = 1'($urandom);
                        req.reel   = REEL_W'($urandom);
                        req.idx    = INDEX_W'($urandom);
                        req.weight = WEIGHT_W'($urandom);
                        req.stop   = STOP_W'($urandom);
                        send_request(req, 1'b0, '0);
                    end
                end
            endcase
        end
        no_gap     = 1'b0;
        i_s_tvalid <= 1'b0;

        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d from the directed table), checked %0d positions",
                 req_cnt, plan.size(), res_cnt);
        $display("Result status: %0d ok, %0d stop out of range, %0d empty reel",
                 status_cnt[STAT_OK], status_cnt[STAT_RANGE], status_cnt[STAT_EMPTY]);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result side back-pressure
    always @(negedge i_clk) begin
        i_m_tready <= no_gap ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_stop_res got;
        t_stop_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.reel   = o_m_tdata[2:0];
            got.pos    = o_m_tdata[10:3];
            got.status = o_m_tdata[12:11];
            res_cnt++;
            if (got.status <= STAT_EMPTY) status_cnt[got.status]++;
            if (pending_positions.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("%0t: unrequested result reel %0d position %0d status %0d",
                             $realtime, got.reel, got.pos, got.status);
            end else begin
                want = pending_positions.pop_front();
                if (got != want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display(
                            "%0t: result %0d reel/pos/status expected %0d/%0d/%0d got %0d/%0d/%0d",
                            $realtime, res_cnt, want.reel, want.pos, want.status,
                            got.reel, got.pos, got.status);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d results outstanding",
                         pending_positions.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
